// ===== rtl/core/u8t_pkg.sv =====
// ============================================================================
// u8t_pkg: shared types and constants for the 8N1 UART transceiver
// Holds the request and result payload types, the frame phase encoding,
// the status bundles each half passes up and the bit timer helper.
// ============================================================================
package u8t_pkg;

    // Width of the bit timer and of the bit period register.
    localparam int unsigned CNT_W = 16;

    // Bit period after reset, in ticks per serial bit.
    localparam logic [CNT_W-1:0] BIT_PERIOD_RESET = 16'd104;

    // Configuration address decode: register index taken from paddr[2].
    localparam int unsigned PADDR_W = 3;
    localparam logic REG_BIT_PERIOD = 1'b0;

    // Phases of a serial frame, shared by both halves.
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_START = 2'd1,
        PH_DATA  = 2'd2,
        PH_STOP  = 2'd3
    } t_phase;

    // One input request: one tick of the serial line.
    typedef struct packed {
        logic       func;
        logic       rx_level;
        logic [7:0] tx_data;
    } t_in_item;

    // One result per tick.
    typedef struct packed {
        logic       tx_line;
        logic       tx_busy;
        logic [7:0] rx_byte;
        logic       rx_valid;
        logic       rx_busy;
    } t_out_item;

    // Status of the transmitter after the current tick.
    typedef struct packed {
        logic line;
        logic busy;
    } t_tx_status;

    // Status of the receiver after the current tick.
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       valid;
        logic       busy;
    } t_rx_status;

    // Result of advancing a bit timer by one tick.
    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] count;
    } t_timer;

    // Advance a bit timer; the bit ends when count plus one reaches len.
    function automatic t_timer bit_step(input logic [CNT_W-1:0] count,
                                        input logic [CNT_W-1:0] len);
        logic [CNT_W:0] nxt;
        t_timer         res;
        nxt = {1'b0, count} + {{CNT_W{1'b0}}, 1'b1};
        if (nxt >= {1'b0, len}) begin
            res.done  = 1'b1;
            res.count = '0;
        end else begin
            res.done  = 1'b0;
            res.count = nxt[CNT_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/u8t_tx.sv =====
// ============================================================================
// u8t_tx: 8N1 transmitter state for one tick per enable
// Loads a byte from an idle state on a send request and sends start bit,
// data bits LSB first and stop bit, each for bit_period ticks.
// ============================================================================
module u8t_tx #(
    parameter int unsigned DATA_BITS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_func,
    input  logic [7:0]                  i_tx_data,
    input  logic [u8t_pkg::CNT_W-1:0]   i_bit_period,
    output u8t_pkg::t_tx_status         o_status
);

    localparam logic [2:0] LAST_BIT = 3'(DATA_BITS - 1);

    u8t_pkg::t_phase             r_phase, n_phase;
    logic [2:0]                  r_idx, n_idx;
    logic [7:0]                  r_shift, n_shift;
    logic [u8t_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    u8t_pkg::t_timer             tmr;

    // State registers, advanced once per accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= u8t_pkg::PH_IDLE;
            r_idx   <= '0;
            r_shift <= '0;
            r_cnt   <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_shift <= n_shift;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and the line level that follows from it.
    always_comb begin
        tmr     = u8t_pkg::bit_step(r_cnt, i_bit_period);
        n_phase = r_phase;
        n_idx   = r_idx;
        n_shift = r_shift;
        n_cnt   = r_cnt;
        unique case (r_phase)
            u8t_pkg::PH_IDLE: begin
                if (i_func) begin
                    n_shift = i_tx_data;
                    n_phase = u8t_pkg::PH_START;
                    n_cnt   = '0;
                    n_idx   = '0;
                end
            end
            u8t_pkg::PH_START: begin
                n_cnt = tmr.count;
                if (tmr.done) begin
                    n_phase = u8t_pkg::PH_DATA;
                    n_idx   = '0;
                end
            end
            u8t_pkg::PH_DATA: begin
                n_cnt = tmr.count;
                if (tmr.done) begin
                    if (r_idx >= LAST_BIT) begin
                        n_phase = u8t_pkg::PH_STOP;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            u8t_pkg::PH_STOP: begin
                n_cnt = tmr.count;
                if (tmr.done) begin
                    n_phase = u8t_pkg::PH_IDLE;
                end
            end
            default: begin
                n_phase = u8t_pkg::PH_IDLE;
            end
        endcase

        // Line is low in the start bit, the data bit in data, high otherwise.
        unique case (n_phase)
            u8t_pkg::PH_START: o_status.line = 1'b0;
            u8t_pkg::PH_DATA:  o_status.line = n_shift[n_idx];
            default:           o_status.line = 1'b1;
        endcase
        o_status.busy = (n_phase != u8t_pkg::PH_IDLE);
    end

endmodule

// ===== rtl/core/u8t_rx.sv =====
// ============================================================================
// u8t_rx: 8N1 receiver state for one tick per enable
// Detects the start bit, waits half a bit, samples the data bits one bit
// apart LSB first, waits to mid stop bit and then reports the byte.
// ============================================================================
module u8t_rx #(
    parameter int unsigned DATA_BITS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_rx_level,
    input  logic [u8t_pkg::CNT_W-1:0]   i_bit_period,
    output u8t_pkg::t_rx_status         o_status
);

    localparam logic [2:0] LAST_BIT = 3'(DATA_BITS - 1);

    u8t_pkg::t_phase             r_phase, n_phase;
    logic [2:0]                  r_idx, n_idx;
    logic [7:0]                  r_shift, n_shift;
    logic [7:0]                  r_last, n_last;
    logic [u8t_pkg::CNT_W-1:0]   r_cnt, n_cnt;
    logic                        n_valid;
    u8t_pkg::t_timer             tmr_half;
    u8t_pkg::t_timer             tmr_full;

    // State registers, advanced once per accepted tick.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= u8t_pkg::PH_IDLE;
            r_idx   <= '0;
            r_shift <= '0;
            r_last  <= '0;
            r_cnt   <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_shift <= n_shift;
            r_last  <= n_last;
            r_cnt   <= n_cnt;
        end
    end

    // Next state; the start phase times half a bit, the others a full bit.
    always_comb begin
        tmr_half = u8t_pkg::bit_step(r_cnt, {1'b0, i_bit_period[u8t_pkg::CNT_W-1:1]});
        tmr_full = u8t_pkg::bit_step(r_cnt, i_bit_period);
        n_phase  = r_phase;
        n_idx    = r_idx;
        n_shift  = r_shift;
        n_last   = r_last;
        n_cnt    = r_cnt;
        n_valid  = 1'b0;
        unique case (r_phase)
            u8t_pkg::PH_IDLE: begin
                if (!i_rx_level) begin
                    n_phase = u8t_pkg::PH_START;
                    n_cnt   = '0;
                    n_idx   = '0;
                    n_shift = '0;
                end
            end
            u8t_pkg::PH_START: begin
                n_cnt = tmr_half.count;
                if (tmr_half.done) begin
                    n_phase = u8t_pkg::PH_DATA;
                    n_idx   = '0;
                end
            end
            u8t_pkg::PH_DATA: begin
                n_cnt = tmr_full.count;
                if (tmr_full.done) begin
                    n_shift[r_idx] = r_shift[r_idx] | i_rx_level;
                    if (r_idx >= LAST_BIT) begin
                        n_phase = u8t_pkg::PH_STOP;
                    end else begin
                        n_idx = r_idx + 3'd1;
                    end
                end
            end
            u8t_pkg::PH_STOP: begin
                n_cnt = tmr_full.count;
                if (tmr_full.done) begin
                    n_phase = u8t_pkg::PH_IDLE;
                    n_last  = r_shift;
                    n_valid = 1'b1;
                end
            end
            default: begin
                n_phase = u8t_pkg::PH_IDLE;
            end
        endcase

        o_status.rx_byte = n_last;
        o_status.valid   = n_valid;
        o_status.busy    = (n_phase != u8t_pkg::PH_IDLE);
    end

endmodule

// ===== rtl/core/uart_8n1_transceiver.sv =====
// ============================================================================
// uart_8n1_transceiver: tick-driven 8N1 UART transmitter and receiver
// Each accepted request is one tick of the serial line; each tick yields one
// result with the transmit line, the busy flags and any received byte.
//
//   Channel   Direction  Handshake                      Payload
//   in        request    i_in_valid / o_in_ready        i_in  (t_in_item)
//   out       result     o_out_valid / i_out_ready      o_out (t_out_item)
//   config    APB r/w    psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// One tick is accepted per clock unless the output side stalls; its result
// sits in the output register in the following cycle, and throughput is one.
// The output register alone sets the rate: a new request is taken whenever
// the register is empty or its result is taken in the same cycle.
// When the output side stalls, o_in_ready drops and the state holds.
// Reset is synchronous and active low; bit_period returns to 104.
// ============================================================================
module uart_8n1_transceiver #(
    parameter int unsigned DATA_BITS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Tick requests
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  u8t_pkg::t_in_item                i_in,
    // Results
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output u8t_pkg::t_out_item               o_out,
    // Configuration port
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [u8t_pkg::PADDR_W-1:0]      paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    logic                           in_fire;
    logic                           cfg_wr;
    logic [u8t_pkg::CNT_W-1:0]      r_bit_period;
    logic                           r_out_valid;
    u8t_pkg::t_out_item             r_out;
    u8t_pkg::t_tx_status            tx_status;
    u8t_pkg::t_rx_status            rx_status;

    // Configuration register, written in the access phase.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == u8t_pkg::REG_BIT_PERIOD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_period <= u8t_pkg::BIT_PERIOD_RESET;
        end else if (cfg_wr) begin
            r_bit_period <= pwdata[u8t_pkg::CNT_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == u8t_pkg::REG_BIT_PERIOD) begin
            prdata = {16'd0, r_bit_period};
        end else begin
            prdata = '0;
        end
    end

    // Request acceptance: free whenever the result register can take a new value.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    u8t_tx #(
        .DATA_BITS    (DATA_BITS)
    ) u_tx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (in_fire),
        .i_func       (i_in.func),
        .i_tx_data    (i_in.tx_data),
        .i_bit_period (r_bit_period),
        .o_status     (tx_status)
    );

    u8t_rx #(
        .DATA_BITS    (DATA_BITS)
    ) u_rx (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (in_fire),
        .i_rx_level   (i_in.rx_level),
        .i_bit_period (r_bit_period),
        .o_status     (rx_status)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_out_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_out.tx_line  <= tx_status.line;
            r_out.tx_busy  <= tx_status.busy;
            r_out.rx_byte  <= rx_status.rx_byte;
            r_out.rx_valid <= rx_status.valid;
            r_out.rx_busy  <= rx_status.busy;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== rtl/core/u8t_checker.sv =====
// ============================================================================
// u8t_checker: port-level checks for the UART transceiver
// Watches the top-level ports and flags handshake and result slips.
// ============================================================================
module u8t_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 o_in_ready,
    input  logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  u8t_pkg::t_out_item   o_out
);

    // A stalled result stays put until it is taken.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("result changed while stalled");

    // The result register is empty in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // With no result waiting, a new request is always taken.
    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("request refused with empty result register");

    // A completed byte leaves the receiver idle.
    a_rx_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.rx_valid |-> !o_out.rx_busy)
        else $error("receiver busy on byte completion");

    // An idle transmitter holds the line high.
    a_tx_idle_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out.tx_busy |-> o_out.tx_line)
        else $error("transmit line low while idle");

endmodule

bind uart_8n1_transceiver u8t_checker u_u8t_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

// ===== bench/uart_8n1_transceiver_tb.sv =====
// ============================================================================
// uart_8n1_transceiver_tb: self-checking bench for the tick-driven 8N1 UART
// A short table of directed ticks comes first. Then come phases of random
// ticks, each with its own bit period. The receive line carries real frames
// at that period, mixed with glitches, jittered bits and low stop bits.
// Every accepted tick runs through a local model of both halves. Each result
// is compared field by field with the oldest prediction.
// ============================================================================
module uart_8n1_transceiver_tb;

    localparam int DATA_BITS = 8;
    localparam logic [2:0] LAST_BIT = 3'(DATA_BITS - 1);

    // Watchdog limit in cycles without any request or result moving.
    localparam int WD_LIMIT = 1000;

    // Output-side stall patterns.
    localparam int READY_ALWAYS   = 0;
    localparam int READY_RANDOM   = 1;
    localparam int READY_PERIODIC = 2;

    // Random phases: bit period and tick count of each.
    localparam int PHASES = 8;
    localparam logic [15:0] PHASE_PERIOD [PHASES] =
        '{16'd2, 16'd3, 16'd2, 16'd5, 16'd65535, 16'd4, 16'd2, 16'd3};
    localparam int PHASE_TICKS = 85;
    localparam int SLOW_PHASE_TICKS = 30;

    // One row of the directed table; want is used only where typed is set.
    typedef struct packed {
        logic [15:0]        period;
        logic               func;
        logic               rx_level;
        logic [7:0]         tx_data;
        logic               typed;
        u8t_pkg::t_out_item want;
    } t_dir_row;

    localparam int DIR_N = 24;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    u8t_pkg::t_in_item  i_in = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    u8t_pkg::t_out_item o_out;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [u8t_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0]        pwdata = '0;
    logic [31:0]        prdata;
    logic               pready;

    uart_8n1_transceiver #(.DATA_BITS(DATA_BITS)) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Clock with a period of 20.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predicted results waiting for the output side.
    u8t_pkg::t_out_item tick_results_q [$];
    int                 mismatch_count = 0;

    // Model copy of the configuration and of both halves.
    logic [15:0]     mdl_period = u8t_pkg::BIT_PERIOD_RESET;
    u8t_pkg::t_phase mdl_tx_ph = u8t_pkg::PH_IDLE;
    logic [2:0]      mdl_tx_idx = '0;
    logic [7:0]      mdl_tx_shift = '0;
    logic [15:0]     mdl_tx_cnt = '0;
    u8t_pkg::t_phase mdl_rx_ph = u8t_pkg::PH_IDLE;
    logic [2:0]      mdl_rx_idx = '0;
    logic [7:0]      mdl_rx_shift = '0;
    logic [15:0]     mdl_rx_cnt = '0;
    logic [7:0]      mdl_rx_last = '0;

    // Stimulus shaping, set per phase.
    int stall_mode = READY_RANDOM;
    int stall_cyc = 0;
    bit gaps_on = 1'b1;
    int burst_left = 0;
    int func_pct = 20;
    u8t_pkg::t_in_item tick_plan_q [$];
    logic              rx_line_q [$];

    // Print one line per mismatch and count it.
    task automatic flag_mismatch(input string msg);
        mismatch_count++;
        $display("ERROR: %s", msg);
    endtask

    // One tick of a bit timer: the bit ends when count plus one reaches len.
    task automatic advance_bit_timer(inout logic [15:0] cnt, input logic [15:0] len,
                                     output logic done);
        logic [16:0] nxt;
        nxt = {1'b0, cnt} + 17'd1;
        if (nxt >= {1'b0, len}) begin
            cnt  = '0;
            done = 1'b1;
        end else begin
            cnt  = nxt[15:0];
            done = 1'b0;
        end
    endtask

    // Advance both halves by one tick and form the result seen after it.
    task automatic uart_tick_model(input u8t_pkg::t_in_item it,
                                   output u8t_pkg::t_out_item res);
        logic done;
        logic got_byte;
        got_byte = 1'b0;

        // Transmitter: a request is taken only while idle.
        if (mdl_tx_ph == u8t_pkg::PH_IDLE) begin
            if (it.func) begin
                mdl_tx_shift = it.tx_data;
                mdl_tx_ph    = u8t_pkg::PH_START;
                mdl_tx_cnt   = '0;
                mdl_tx_idx   = '0;
            end
        end else begin
            advance_bit_timer(mdl_tx_cnt, mdl_period, done);
            if (done) begin
                case (mdl_tx_ph)
                    u8t_pkg::PH_START: begin
                        mdl_tx_ph  = u8t_pkg::PH_DATA;
                        mdl_tx_idx = '0;
                    end
                    u8t_pkg::PH_DATA: begin
                        if (mdl_tx_idx >= LAST_BIT)
                            mdl_tx_ph = u8t_pkg::PH_STOP;
                        else
                            mdl_tx_idx = mdl_tx_idx + 3'd1;
                    end
                    default: mdl_tx_ph = u8t_pkg::PH_IDLE;
                endcase
            end
        end

        // Receiver: start on a low level, half-bit wait, then one bit apart.
        if (mdl_rx_ph == u8t_pkg::PH_IDLE) begin
            if (!it.rx_level) begin
                mdl_rx_ph    = u8t_pkg::PH_START;
                mdl_rx_cnt   = '0;
                mdl_rx_idx   = '0;
                mdl_rx_shift = '0;
            end
        end else if (mdl_rx_ph == u8t_pkg::PH_START) begin
            advance_bit_timer(mdl_rx_cnt, mdl_period >> 1, done);
            if (done) begin
                mdl_rx_ph  = u8t_pkg::PH_DATA;
                mdl_rx_idx = '0;
            end
        end else begin
            advance_bit_timer(mdl_rx_cnt, mdl_period, done);
            if (done) begin
                if (mdl_rx_ph == u8t_pkg::PH_DATA) begin
                    mdl_rx_shift = mdl_rx_shift | (8'(it.rx_level) << mdl_rx_idx);
                    if (mdl_rx_idx >= LAST_BIT)
                        mdl_rx_ph = u8t_pkg::PH_STOP;
                    else
                        mdl_rx_idx = mdl_rx_idx + 3'd1;
                end else begin
                    // The stop level is not checked; the byte is reported anyway.
                    mdl_rx_ph   = u8t_pkg::PH_IDLE;
                    mdl_rx_last = mdl_rx_shift;
                    got_byte    = 1'b1;
                end
            end
        end

        if (mdl_tx_ph == u8t_pkg::PH_START)
            res.tx_line = 1'b0;
        else if (mdl_tx_ph == u8t_pkg::PH_DATA)
            res.tx_line = mdl_tx_shift[mdl_tx_idx];
        else
            res.tx_line = 1'b1;
        res.tx_busy  = (mdl_tx_ph != u8t_pkg::PH_IDLE);
        res.rx_byte  = mdl_rx_last;
        res.rx_valid = got_byte;
        res.rx_busy  = (mdl_rx_ph != u8t_pkg::PH_IDLE);
    endtask

    // Offer one tick request, with a random gap between bursts while gaps_on
    // is set, and record its expected result once it is accepted.
    task automatic send_tick(input u8t_pkg::t_in_item it, input logic typed,
                             input u8t_pkg::t_out_item want);
        u8t_pkg::t_out_item pred;
        if (gaps_on && burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        i_in_valid <= 1'b1;
        i_in       <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        uart_tick_model(it, pred);
        tick_results_q.push_back(typed ? want : pred);
        if (burst_left > 0)
            burst_left--;
    endtask

    // Stop offering requests and wait until every result has come out.
    task automatic settle_block();
        i_in_valid <= 1'b0;
        while (tick_results_q.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // Write the bit period, then read it back.
    task automatic write_bit_period(input logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {u8t_pkg::REG_BIT_PERIOD, 2'b00};
        pwdata  <= {16'h0000, value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        mdl_period = value;
        @(posedge i_clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== {16'h0000, value})
            flag_mismatch($sformatf("bit_period read %08h, wrote %04h", prdata, value));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Append len ticks of one line level, never past n ticks in all.
    task automatic push_level(input logic lvl, input int len, input int n);
        for (int k = 0; k < len && rx_line_q.size() < n; k++)
            rx_line_q.push_back(lvl);
    endtask

    // Build n ticks: receive frames at the current period plus random sends.
    task automatic build_phase(input int n);
        int                kind;
        int                blen;
        logic [7:0]        byte_val;
        int                per;
        u8t_pkg::t_in_item it;
        per = int'(mdl_period);
        rx_line_q.delete();
        tick_plan_q.delete();
        while (rx_line_q.size() < n) begin
            kind = $urandom_range(0, 9);
            if (kind == 0) begin
                // Glitches: random levels for a few bit times.
                repeat ($urandom_range(1, 3 * per))
                    push_level(1'($urandom_range(0, 1)), 1, n);
            end else begin
                byte_val = (kind == 3) ? 8'h00 : (kind == 4) ? 8'hFF : 8'($urandom);
                push_level(1'b1, $urandom_range(0, 2 * per), n);
                push_level(1'b0, per, n);
                for (int b = 0; b < 8; b++) begin
                    blen = per;
                    // Jittered bits: one tick long or short.
                    if (kind == 1)
                        blen = per + $urandom_range(0, 2) - 1;
                    push_level(byte_val[b], (blen < 1) ? 1 : blen, n);
                end
                // A low stop bit now and then.
                push_level(kind != 2, per, n);
            end
        end
        for (int i = 0; i < n; i++) begin
            it.func     = ($urandom_range(0, 99) < func_pct);
            it.rx_level = rx_line_q[i];
            it.tx_data  = 8'($urandom);
            tick_plan_q.push_back(it);
        end
    endtask

    // Output-side ready pattern.
    always @(posedge i_clk) begin
        stall_cyc <= stall_cyc + 1;
        case (stall_mode)
            READY_ALWAYS: i_out_ready <= 1'b1;
            READY_RANDOM: i_out_ready <= ($urandom_range(0, 3) != 0);
            default: i_out_ready <= ((stall_cyc % 9) >= 3);
        endcase
    end

    // Compare each result with the oldest prediction.
    always @(posedge i_clk) begin
        u8t_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (tick_results_q.size() == 0) begin
                flag_mismatch("result with no tick outstanding");
            end else begin
                want = tick_results_q.pop_front();
                if (o_out.tx_line !== want.tx_line || o_out.tx_busy !== want.tx_busy ||
                    o_out.rx_byte !== want.rx_byte || o_out.rx_valid !== want.rx_valid ||
                    o_out.rx_busy !== want.rx_busy)
                    flag_mismatch($sformatf(
                        "got line %b busy %b byte %02h valid %b rxbusy %b, %s %b %b %02h %b %b",
                        o_out.tx_line, o_out.tx_busy, o_out.rx_byte, o_out.rx_valid,
                        o_out.rx_busy, "want", want.tx_line, want.tx_busy, want.rx_byte,
                        want.rx_valid, want.rx_busy));
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long.
    int idle_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WD_LIMIT) begin
            $display("uart_8n1_transceiver: mismatch");
            $finish;
        end
    end

    // Main sequence: reset, directed table, random phases, drain.
    initial begin
        t_dir_row          dir_rows [0:DIR_N-1];
        t_dir_row          row;
        u8t_pkg::t_in_item it;

        // After reset at period 104: typed rows, then a switch to period 2
        // in the middle of both frames, a request while busy, a low stop bit
        // and requests around the end of the transmit frame.
        dir_rows = '{
            '{16'd0, 1'b0, 1'b1, 8'h00, 1'b1, '{1'b1, 1'b0, 8'h00, 1'b0, 1'b0}},
            '{16'd0, 1'b1, 1'b1, 8'hA5, 1'b1, '{1'b0, 1'b1, 8'h00, 1'b0, 1'b0}},
            '{16'd0, 1'b1, 1'b0, 8'h00, 1'b1, '{1'b0, 1'b1, 8'h00, 1'b0, 1'b1}},
            '{16'd0, 1'b0, 1'b1, 8'hFF, 1'b1, '{1'b0, 1'b1, 8'h00, 1'b0, 1'b1}},
            '{16'd2, 1'b0, 1'b0, 8'h00, 1'b0, '0},
            '{16'd0, 1'b0, 1'b0, 8'h00, 1'b0, '0},
            '{16'd0, 1'b0, 1'b1, 8'h00, 1'b0, '0},
            '{16'd0, 1'b0, 1'b1, 8'h00, 1'b0, '0},
            '{16'd0, 1'b0, 1'b0, 8'h00, 1'b0, '0},
            '{16'd0, 1'b0, 1'b0, 8'h00, 1'b0, '0},
            '{16'd0, 1'b0, 1'b1, 8'h00, 1'b0, '0},
            '{16'd0, 1'b0, 1'b1, 8'h00, 1'b0, '0},
            '{16'd0, 1'b1, 1'b0, 8'hFF, 1'b0, '0},
            '{16'd0, 1'b0, 1'b0, 8'h00, 1'b0, '0},
            '{16'd0, 1'b0, 1'b1, 8'h00, 1'b0, '0},
            '{16'd0, 1'b0, 1'b1, 8'h00, 1'b0, '0},
            '{16'd0, 1'b0, 1'b0, 8'h00, 1'b0, '0},
            '{16'd0, 1'b0, 1'b0, 8'h00, 1'b0, '0},
            '{16'd0, 1'b0, 1'b1, 8'h00, 1'b0, '0},
            '{16'd0, 1'b0, 1'b1, 8'h00, 1'b0, '0},
            '{16'd0, 1'b0, 1'b0, 8'h00, 1'b0, '0},
            '{16'd0, 1'b0, 1'b0, 8'h00, 1'b0, '0},
            '{16'd0, 1'b1, 1'b0, 8'h00, 1'b0, '0},
            '{16'd0, 1'b1, 1'b0, 8'h5A, 1'b0, '0}
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table.
        for (int i = 0; i < DIR_N; i++) begin
            row = dir_rows[i];
            if (row.period != 16'd0) begin
                settle_block();
                write_bit_period(row.period);
            end
            it.func     = row.func;
            it.rx_level = row.rx_level;
            it.tx_data  = row.tx_data;
            send_tick(it, row.typed, row.want);
        end

        // Random phases, each at its own period and pacing.
        for (int p = 0; p < PHASES; p++) begin
            settle_block();
            write_bit_period(PHASE_PERIOD[p]);
            stall_mode = p % 3;
            gaps_on    = (p % 4) != 1;
            func_pct   = (p % 2) ? 60 : 15;
            build_phase((PHASE_PERIOD[p] > 16'd100) ? SLOW_PHASE_TICKS : PHASE_TICKS);
            foreach (tick_plan_q[i])
                send_tick(tick_plan_q[i], 1'b0, '0);
        end

        settle_block();
        repeat (3) @(posedge i_clk);
        if (tick_results_q.size() != 0)
            flag_mismatch("results still outstanding at the end");
        if (mismatch_count == 0)
            $display("uart_8n1_transceiver: match");
        else
            $display("uart_8n1_transceiver: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/u8t_pkg.sv
rtl/core/u8t_tx.sv
rtl/core/u8t_rx.sv
rtl/core/uart_8n1_transceiver.sv
rtl/core/u8t_checker.sv
bench/uart_8n1_transceiver_tb.sv
